>>> rtl/gha_pkg.sv
// Package for the generational handle allocator.
// Holds sizes, request and status codes and the controller/datapath structs.
// Depends on nothing; every other file of the block uses it.
package gha_pkg;

  localparam int unsigned MAX_HANDLES = 1024;
  localparam int unsigned IDX_W = $clog2(MAX_HANDLES);
  localparam int unsigned CNT_W = IDX_W + 1;
  localparam int unsigned GEN_W = 16;
  localparam int unsigned MODE_W = 2;
  localparam int unsigned STATUS_W = 2;

  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_HANDLES);

  localparam logic [MODE_W-1:0] MODE_CREATE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DESTROY = 2'd1;
  localparam logic [MODE_W-1:0] MODE_QUERY = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_DEAD = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

  typedef struct packed {
    logic latch;
    logic rd_first;
    logic rd_pop;
    logic exec;
  } gha_cmd_t;

  typedef struct packed {
    logic is_create;
    logic fifo_nonempty;
  } gha_stat_t;

endpackage

>>> rtl/gha_if.sv
// Valid/ready channel interfaces for the request and response transactions.
// Depends on gha_pkg for the field widths.
interface gha_req_if;
  logic                          valid;
  logic                          ready;
  logic [gha_pkg::MODE_W-1:0]    mode;
  logic [gha_pkg::IDX_W-1:0]     handle_index;
  logic [gha_pkg::GEN_W-1:0]     handle_generation;

  modport source (output valid, output mode, output handle_index,
                  output handle_generation, input ready);
  modport sink (input valid, input mode, input handle_index,
                input handle_generation, output ready);
endinterface

interface gha_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [gha_pkg::STATUS_W-1:0]  status;
  logic [gha_pkg::IDX_W-1:0]     out_index;
  logic [gha_pkg::GEN_W-1:0]     out_generation;
  logic [gha_pkg::IDX_W-1:0]     living_count;

  modport source (output valid, output status, output out_index,
                  output out_generation, output living_count, input ready);
  modport sink (input valid, input status, input out_index,
                input out_generation, input living_count, output ready);
endinterface

>>> rtl/gha_ctrl.sv
// Controller state machine of the handle allocator: sequences the memory
// reads and the execute step, and owns the response valid flag.
// Depends on gha_pkg.
module gha_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  output logic              rsp_valid_o,
  input  logic              rsp_ready_i,
  input  gha_pkg::gha_stat_t stat_i,
  output gha_pkg::gha_cmd_t  cmd_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_FOLLOW = 2'd2;
  localparam logic [1:0] ST_EXEC = 2'd3;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    req_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        cmd_o.rd_first = 1'b1;
        state_d = (stat_i.is_create && stat_i.fifo_nonempty) ? ST_FOLLOW : ST_EXEC;
      end
      ST_FOLLOW: begin
        cmd_o.rd_pop = 1'b1;
        state_d = ST_EXEC;
      end
      ST_EXEC: begin
        if (!out_valid_q || rsp_ready_i) begin
          cmd_o.exec = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_d = cmd_o.exec | (out_valid_q & ~rsp_ready_i);
  assign rsp_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_exec_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.exec |=> out_valid_q)
    else $error("execute step did not present a response");

  a_exec_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.exec |-> (!out_valid_q || rsp_ready_i))
    else $error("execute step overwrote a pending response");

  a_pop_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.rd_pop |-> $past(cmd_o.rd_first))
    else $error("free list read without a preceding first read");

endmodule

>>> rtl/gha_dp.sv
// Datapath of the handle allocator: generation table with alive bits, free
// index ring, counters and the response register. Depends on gha_pkg.
module gha_dp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  gha_pkg::gha_cmd_t              cmd_i,
  output gha_pkg::gha_stat_t             stat_o,
  input  logic [gha_pkg::MODE_W-1:0]     mode_i,
  input  logic [gha_pkg::IDX_W-1:0]      handle_index_i,
  input  logic [gha_pkg::GEN_W-1:0]      handle_generation_i,
  output logic [gha_pkg::STATUS_W-1:0]   status_o,
  output logic [gha_pkg::IDX_W-1:0]      out_index_o,
  output logic [gha_pkg::GEN_W-1:0]      out_generation_o,
  output logic [gha_pkg::IDX_W-1:0]      living_count_o
);

  localparam int unsigned IDX_W = gha_pkg::IDX_W;
  localparam int unsigned CNT_W = gha_pkg::CNT_W;
  localparam int unsigned GEN_W = gha_pkg::GEN_W;

  // Each entry holds the alive bit above the generation.
  logic [GEN_W:0]       gen_mem [gha_pkg::MAX_HANDLES];
  logic [IDX_W-1:0]     fifo_mem [gha_pkg::MAX_HANDLES];

  logic [gha_pkg::MODE_W-1:0] mode_q;
  logic [IDX_W-1:0]     idx_q;
  logic [GEN_W-1:0]     gen_q;
  logic [IDX_W-1:0]     fifo_rd_q;
  logic [GEN_W:0]       gen_rd_q;

  logic [IDX_W-1:0]     head_q, head_d, tail_q, tail_d;
  logic [CNT_W-1:0]     count_q, count_d, fresh_q, fresh_d;
  logic [IDX_W-1:0]     live_q, live_d;

  logic [gha_pkg::STATUS_W-1:0] status_q, status_d;
  logic [IDX_W-1:0]     oidx_q, oidx_d;
  logic [GEN_W-1:0]     ogen_q, ogen_d;

  logic [IDX_W-1:0]     gen_raddr;
  logic                 gen_we, fifo_we;
  logic [IDX_W-1:0]     gen_waddr;
  logic [GEN_W:0]       gen_wdata;
  logic                 alive;

  assign stat_o.is_create = (mode_q == gha_pkg::MODE_CREATE);
  assign stat_o.fifo_nonempty = (count_q != '0);

  assign gen_raddr = cmd_i.rd_pop ? fifo_rd_q : idx_q;

  // Indices at or above the fresh counter were never issued, so their
  // table entries are never consulted.
  assign alive = (idx_q != '0) && ({1'b0, idx_q} < fresh_q) && gen_rd_q[GEN_W]
                 && (gen_rd_q[GEN_W-1:0] == gen_q);

  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    count_d = count_q;
    fresh_d = fresh_q;
    live_d = live_q;
    gen_we = 1'b0;
    fifo_we = 1'b0;
    gen_waddr = idx_q;
    gen_wdata = gen_rd_q;
    status_d = alive ? gha_pkg::STATUS_OK : gha_pkg::STATUS_DEAD;
    oidx_d = idx_q;
    ogen_d = gen_q;
    if (mode_q == gha_pkg::MODE_CREATE) begin
      if (count_q != '0) begin
        status_d = gha_pkg::STATUS_OK;
        oidx_d = fifo_rd_q;
        ogen_d = gen_rd_q[GEN_W-1:0];
        gen_we = 1'b1;
        gen_waddr = fifo_rd_q;
        gen_wdata = {1'b1, gen_rd_q[GEN_W-1:0]};
        head_d = head_q + IDX_W'(1);
        count_d = count_q - CNT_W'(1);
        live_d = live_q + IDX_W'(1);
      end else if (fresh_q < gha_pkg::MAX_CNT) begin
        status_d = gha_pkg::STATUS_OK;
        oidx_d = fresh_q[IDX_W-1:0];
        ogen_d = '0;
        gen_we = 1'b1;
        gen_waddr = fresh_q[IDX_W-1:0];
        gen_wdata = {1'b1, {GEN_W{1'b0}}};
        fresh_d = fresh_q + CNT_W'(1);
        live_d = live_q + IDX_W'(1);
      end else begin
        status_d = gha_pkg::STATUS_FULL;
        oidx_d = '0;
        ogen_d = '0;
      end
    end else if (mode_q == gha_pkg::MODE_DESTROY && alive) begin
      gen_we = 1'b1;
      gen_wdata = {1'b0, gen_rd_q[GEN_W-1:0] + GEN_W'(1)};
      if (count_q < gha_pkg::MAX_CNT) begin
        fifo_we = 1'b1;
        tail_d = tail_q + IDX_W'(1);
        count_d = count_q + CNT_W'(1);
      end
      if (live_q != '0) begin
        live_d = live_q - IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      mode_q <= mode_i;
      idx_q <= handle_index_i;
      gen_q <= handle_generation_i;
    end
    if (cmd_i.rd_first) begin
      fifo_rd_q <= fifo_mem[head_q];
    end
    if (cmd_i.rd_first || cmd_i.rd_pop) begin
      gen_rd_q <= gen_mem[gen_raddr];
    end
    if (cmd_i.exec && gen_we) begin
      gen_mem[gen_waddr] <= gen_wdata;
    end
    if (cmd_i.exec && fifo_we) begin
      fifo_mem[tail_q] <= idx_q;
    end
    if (cmd_i.exec) begin
      status_q <= status_d;
      oidx_q <= oidx_d;
      ogen_q <= ogen_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      count_q <= '0;
      fresh_q <= CNT_W'(1);
      live_q <= '0;
    end else if (cmd_i.exec) begin
      head_q <= head_d;
      tail_q <= tail_d;
      count_q <= count_d;
      fresh_q <= fresh_d;
      live_q <= live_d;
    end
  end

  assign status_o = status_q;
  assign out_index_o = oidx_q;
  assign out_generation_o = ogen_q;
  assign living_count_o = live_q;

  a_index_conservation: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, live_q} + count_q) == (fresh_q - CNT_W'(1)))
    else $error("live and free indices do not account for all issued ones");

  a_fifo_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= gha_pkg::MAX_CNT)
    else $error("free ring count beyond capacity");

  a_create_not_null: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.exec && mode_q == gha_pkg::MODE_CREATE && status_d == gha_pkg::STATUS_OK)
    |-> (oidx_d != '0))
    else $error("create issued the null index");

endmodule

>>> rtl/generational_handle_allocator_core.sv
// Generational handle allocator, top level. A request passes the read and
// execute states before its registered response; a create that reuses a
// freed index also passes the follow state, since the free ring read must
// complete before the generation table can be read at the index it
// returns. A response waiting in the output register stalls only the
// execute step of the following request. There is no clearing pass: table
// entries at or above the fresh index counter are never consulted.
// Depends on gha_pkg, gha_if, gha_ctrl and gha_dp.
module generational_handle_allocator_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  gha_req_if.sink       req_i,
  gha_rsp_if.source     rsp_o
);

  gha_pkg::gha_cmd_t  cmd;
  gha_pkg::gha_stat_t stat;

  gha_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  gha_dp u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .stat_o              (stat),
    .mode_i              (req_i.mode),
    .handle_index_i      (req_i.handle_index),
    .handle_generation_i (req_i.handle_generation),
    .status_o            (rsp_o.status),
    .out_index_o         (rsp_o.out_index),
    .out_generation_o    (rsp_o.out_generation),
    .living_count_o      (rsp_o.living_count)
  );

endmodule
